### src/mdhfk_pkg.sv
// Shared types, fixed-point constants and link geometry for the forward kinematics pipeline.
package mdhfk_pkg;

  localparam int JOINT_COUNT = 6;
  localparam int SC_LAT = 11;

  localparam logic [23:0] TURN_MUL = 24'd10680707;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam int DIV_S42 = 36;
  localparam int DIV_S56 = 36;
  localparam int DIV_S20 = 35;
  localparam int DIV_S30 = 35;
  localparam int DIV_S6 = 33;
  localparam int DIV_S12 = 34;
  localparam logic [31:0] DIV_R42 = 32'(((64'd1 << DIV_S42) + 64'd41) / 64'd42);
  localparam logic [31:0] DIV_R56 = 32'(((64'd1 << DIV_S56) + 64'd55) / 64'd56);
  localparam logic [31:0] DIV_R20 = 32'(((64'd1 << DIV_S20) + 64'd19) / 64'd20);
  localparam logic [31:0] DIV_R30 = 32'(((64'd1 << DIV_S30) + 64'd29) / 64'd30);
  localparam logic [31:0] DIV_R6 = 32'(((64'd1 << DIV_S6) + 64'd5) / 64'd6);
  localparam logic [31:0] DIV_R12 = 32'(((64'd1 << DIV_S12) + 64'd11) / 64'd12);

  typedef logic signed [31:0] ent_t;
  typedef logic signed [25:0] trig_t;
  typedef ent_t [3:0] row_t;
  typedef row_t [2:0] mat_t;

  typedef struct packed {
    trig_t sn;
    trig_t cs;
  } sc_t;

  typedef struct packed {
    mat_t t;
    sc_t [JOINT_COUNT-1:0] sc;
    logic [2:0] chain_end;
  } lk_t;

  localparam ent_t Q24_ONE = 32'sd16777216;
  localparam ent_t ZERO_ENT = 32'sd0;
  localparam mat_t IDENT_MAT = {
    {ZERO_ENT, Q24_ONE, ZERO_ENT, ZERO_ENT},
    {ZERO_ENT, ZERO_ENT, Q24_ONE, ZERO_ENT},
    {ZERO_ENT, ZERO_ENT, ZERO_ENT, Q24_ONE}
  };

  localparam logic signed [18:0] THETA_OFF [6] = '{
    19'sd0, 19'sd0, 19'sd45238, -19'sd45238, -19'sd25736, 19'sd0
  };
  localparam ent_t LEN_D [6] = '{
    32'sd1073742, 32'sd434530, 32'sd0, -32'sd434532, 32'sd0, -32'sd135057
  };
  localparam ent_t LEN_A [6] = '{
    32'sd0, -32'sd287707, 32'sd3187671, 32'sd2710442, -32'sd825439, 32'sd0
  };
  localparam logic [5:0] ALPHA_RIGHT = 6'b110010;

endpackage

### src/mdhfk_sincos.sv
// Pipelined fixed-point sine and cosine of one joint angle after direction and offset.
module mdhfk_sincos (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [17:0]        angle,
  input  logic                      flip,
  input  logic signed [18:0]        offset,
  output mdhfk_pkg::trig_t          sn,
  output mdhfk_pkg::trig_t          cs
);
  import mdhfk_pkg::*;

  logic signed [18:0] q19;
  logic signed [18:0] th1;
  logic signed [43:0] prod2;
  logic [31:0] ph2;
  logic [29:0] low3;
  logic [29:0] m3;
  logic neg3_next;

  logic [29:0] x3, x4, x5, x6, x7, x8, x9;
  logic [1:0] quad3, quad4, quad5, quad6, quad7, quad8, quad9, quad10;
  logic neg3, neg4, neg5, neg6, neg7, neg8, neg9, neg10;
  logic [29:0] x2_4, x2_5, x2_6, x2_7, x2_8, x2_9;
  logic [29:0] ds5, dc5, ps6, pc6, ds7, dc7, ps8, pc8, ds9, dc9, sx10, pc10;
  logic [30:0] cx11;
  logic [24:0] smag11, cmag11;
  trig_t s11, c11;

  always_comb begin
    q19 = 19'(angle);
    low3 = ph2[29:0];
    neg3_next = ~ph2[29];
    m3 = neg3_next ? (30'h2000_0000 - low3) : (low3 - 30'h2000_0000);
    prod2 = th1 * $signed({1'b0, TURN_MUL});
    cx11 = Q30_ONE - {2'b00, pc10[29:1]};
    smag11 = 25'(({1'b0, sx10} + 31'd32) >> 6);
    cmag11 = 25'((cx11 + 31'd32) >> 6);
    s11 = neg10 ? -$signed({1'b0, smag11}) : $signed({1'b0, smag11});
    c11 = $signed({1'b0, cmag11});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th1 <= (flip ? -q19 : q19) + offset;
      ph2 <= prod2[39:8] + 32'h2000_0000;
      x3 <= 30'((62'(m3) * 62'(HALF_PI_Q30)) >> 30);
      quad3 <= ph2[31:30];
      neg3 <= neg3_next;
      x2_4 <= 30'((60'(x3) * 60'(x3)) >> 30);
      x4 <= x3;
      quad4 <= quad3;
      neg4 <= neg3;
      ds5 <= 30'((62'(x2_4) * 62'(DIV_R42)) >> DIV_S42);
      dc5 <= 30'((62'(x2_4) * 62'(DIV_R56)) >> DIV_S56);
      x2_5 <= x2_4;
      x5 <= x4;
      quad5 <= quad4;
      neg5 <= neg4;
      ps6 <= 30'((61'(x2_5) * 61'(Q30_ONE - {1'b0, ds5})) >> 30);
      pc6 <= 30'((61'(x2_5) * 61'(Q30_ONE - {1'b0, dc5})) >> 30);
      x2_6 <= x2_5;
      x6 <= x5;
      quad6 <= quad5;
      neg6 <= neg5;
      ds7 <= 30'((62'(ps6) * 62'(DIV_R20)) >> DIV_S20);
      dc7 <= 30'((62'(pc6) * 62'(DIV_R30)) >> DIV_S30);
      x2_7 <= x2_6;
      x7 <= x6;
      quad7 <= quad6;
      neg7 <= neg6;
      ps8 <= 30'((61'(x2_7) * 61'(Q30_ONE - {1'b0, ds7})) >> 30);
      pc8 <= 30'((61'(x2_7) * 61'(Q30_ONE - {1'b0, dc7})) >> 30);
      x2_8 <= x2_7;
      x8 <= x7;
      quad8 <= quad7;
      neg8 <= neg7;
      ds9 <= 30'((62'(ps8) * 62'(DIV_R6)) >> DIV_S6);
      dc9 <= 30'((62'(pc8) * 62'(DIV_R12)) >> DIV_S12);
      x2_9 <= x2_8;
      x9 <= x8;
      quad9 <= quad8;
      neg9 <= neg8;
      sx10 <= 30'((61'(x9) * 61'(Q30_ONE - {1'b0, ds9})) >> 30);
      pc10 <= 30'((61'(x2_9) * 61'(Q30_ONE - {1'b0, dc9})) >> 30);
      quad10 <= quad9;
      neg10 <= neg9;
      case (quad10)
        2'd0: begin
          sn <= s11;
          cs <= c11;
        end
        2'd1: begin
          sn <= c11;
          cs <= -s11;
        end
        2'd2: begin
          sn <= -s11;
          cs <= -c11;
        end
        default: begin
          sn <= -c11;
          cs <= s11;
        end
      endcase
    end
  end

endmodule

### src/mdhfk_link.sv
// One joint of the transform chain: multiply the running transform by the link matrix.
module mdhfk_link (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [2:0]        joint,
  input  mdhfk_pkg::ent_t   len_a,
  input  mdhfk_pkg::ent_t   len_d,
  input  logic              alpha,
  input  logic              in_valid,
  input  mdhfk_pkg::lk_t    in_pl,
  output logic              out_valid,
  output mdhfk_pkg::lk_t    out_pl
);
  import mdhfk_pkg::*;

  localparam logic signed [63:0] HALF24 = 64'sd8388608;

  trig_t c, s;
  logic use_next;
  ent_t t0 [3];
  ent_t tk [3];
  ent_t tx [3];
  ent_t col2_next [3];

  logic va;
  lk_t pla;
  logic usea;
  logic signed [63:0] pc0 [3];
  logic signed [63:0] ps0 [3];
  logic signed [63:0] pc1 [3];
  logic signed [63:0] ps1 [3];
  logic signed [63:0] pa [3];
  logic signed [63:0] pd [3];
  ent_t col2 [3];

  lk_t out_next;

  always_comb begin
    c = in_pl.sc[joint].cs;
    s = in_pl.sc[joint].sn;
    use_next = (joint <= in_pl.chain_end) && (in_pl.chain_end < 3'(JOINT_COUNT));
    for (int i = 0; i < 3; i++) begin
      t0[i] = $signed(in_pl.t[i][0]);
      tk[i] = alpha ? $signed(in_pl.t[i][2]) : $signed(in_pl.t[i][1]);
      tx[i] = alpha ? -$signed(in_pl.t[i][1]) : $signed(in_pl.t[i][2]);
      col2_next[i] = tx[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pla <= in_pl;
      usea <= use_next;
      for (int i = 0; i < 3; i++) begin
        pc0[i] <= t0[i] * c;
        ps0[i] <= t0[i] * s;
        pc1[i] <= tk[i] * c;
        ps1[i] <= tk[i] * s;
        pa[i] <= t0[i] * len_a;
        pd[i] <= tx[i] * len_d;
        col2[i] <= col2_next[i];
      end
    end
  end

  always_comb begin
    out_next = pla;
    if (usea) begin
      for (int i = 0; i < 3; i++) begin
        out_next.t[i][0] = 32'((pc0[i] + ps1[i] + HALF24) >>> 24);
        out_next.t[i][1] = 32'((pc1[i] - ps0[i] + HALF24) >>> 24);
        out_next.t[i][2] = col2[i];
        out_next.t[i][3] = $signed(pla.t[i][3]) + 32'((pa[i] + pd[i] + HALF24) >>> 24);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pl <= out_next;
    end
  end

endmodule

### src/mdh_forward_kinematics_6dof.sv
// Top level: six-joint modified-DH forward kinematics, fully pipelined.
//
// Input stream (s_*): one transaction carries six joint angles (signed
// Q3.14 radians) and the chain end index. Output stream (m_*): one
// transaction per input carries the 3x3 rotation and the position of the
// chain end frame in signed Q.16, saturated. A chain end of 6 or 7 gives
// the identity rotation and zero position.
// cfg_we/cfg_wdata write the direction mask; bit i negates joint i+1.
// Write it only while the pipeline is empty. Reset sets it to all ones.
// Throughput: one transaction per cycle unless the receiver stalls. An input
// passes 11 stages of sine/cosine evaluation, two stages per joint for the
// matrix chain, and the output register before m_tvalid.
// Reset clears all valid bits. When the receiver stalls, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated.
module mdh_forward_kinematics_6dof (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [5:0]   cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // angle_joint1..angle_joint6 (18 bits each), chain_end (3), zero pad (1)
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
  // pos_x, pos_y, pos_z (18 bits each)
  output logic [215:0] m_tdata
);
  import mdhfk_pkg::*;

  logic adv;
  logic [5:0] mask;
  logic [SC_LAT-1:0] vd;
  logic [2:0] ed [SC_LAT];
  sc_t [JOINT_COUNT-1:0] lane_sc;
  logic lk_v [JOINT_COUNT+1];
  lk_t lk_pl [JOINT_COUNT+1];
  logic [215:0] out_next;

  function automatic logic [17:0] rnd_sat(input ent_t v, input logic signed [23:0] lo,
                                          input logic signed [23:0] hi);
    logic signed [23:0] r;
    r = 24'(($signed(v) + 32'sd128) >>> 8);
    if (r < lo) begin
      r = lo;
    end else if (r > hi) begin
      r = hi;
    end
    return r[17:0];
  endfunction

  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 6'h3f;
    end else if (cfg_we) begin
      mask <= cfg_wdata;
    end
  end

  genvar j;
  generate
    for (j = 0; j < JOINT_COUNT; j++) begin : g_lane
      mdhfk_sincos u_sc (
        .clk    (clk),
        .en     (adv),
        .angle  ($signed(s_tdata[j*18 +: 18])),
        .flip   (mask[j]),
        .offset (THETA_OFF[j]),
        .sn     (lane_sc[j].sn),
        .cs     (lane_sc[j].cs)
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (adv) begin
      vd <= {vd[SC_LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ed[0] <= s_tdata[110:108];
      for (int k = 1; k < SC_LAT; k++) begin
        ed[k] <= ed[k-1];
      end
    end
  end

  always_comb begin
    lk_v[0] = vd[SC_LAT-1];
    lk_pl[0].t = IDENT_MAT;
    lk_pl[0].sc = lane_sc;
    lk_pl[0].chain_end = ed[SC_LAT-1];
  end

  generate
    for (j = 0; j < JOINT_COUNT; j++) begin : g_link
      mdhfk_link u_link (
        .clk       (clk),
        .rst       (rst),
        .en        (adv),
        .joint     (3'(j)),
        .len_a     (LEN_A[j]),
        .len_d     (LEN_D[j]),
        .alpha     (ALPHA_RIGHT[j]),
        .in_valid  (lk_v[j]),
        .in_pl     (lk_pl[j]),
        .out_valid (lk_v[j+1]),
        .out_pl    (lk_pl[j+1])
      );
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        out_next[(i*3+k)*18 +: 18] = rnd_sat(lk_pl[JOINT_COUNT].t[i][k],
                                             -24'sd65536, 24'sd65536);
      end
      out_next[(9+i)*18 +: 18] = rnd_sat(lk_pl[JOINT_COUNT].t[i][3],
                                         -24'sd131072, 24'sd131071);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= lk_v[JOINT_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= out_next;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vd))
    else $error("valid line moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vd[0])
    else $error("accepted transaction not tracked");

  a_ident_end: assert property (@(posedge clk) disable iff (rst)
    lk_v[JOINT_COUNT] && (lk_pl[JOINT_COUNT].chain_end >= 3'(JOINT_COUNT))
      |-> lk_pl[JOINT_COUNT].t == IDENT_MAT)
    else $error("chain end beyond last joint is not identity");

endmodule

### tb/tb.sv
// Testbench for the six-joint forward kinematics pipeline under input gaps and output stalls.
`timescale 1ns / 100ps

module tb;

  localparam int LATENCY = 24;
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [18:0] ZERO_ANGLE [6] = '{0, 0, 45238, -45238, -25736, 0};
  localparam longint LINK_D [6] = '{1073742, 434530, 0, -434532, 0, -135057};
  localparam longint LINK_A [6] = '{0, -287707, 3187671, 2710442, -825439, 0};
  localparam logic [5:0] TWISTED = 6'b110010;
  localparam longint ONE_Q24 = 64'd16777216;
  localparam longint ONE_Q30 = 64'd1073741824;

  typedef logic signed [17:0] angle_t;
  typedef struct {
    angle_t angle [6];
    logic [2:0] chain_end;
  } pose_t;
  typedef longint frame_t [3][4];

  logic clk;
  logic rst;
  logic cfg_we;
  logic [5:0] cfg_wdata;
  logic s_tvalid;
  logic s_tready;
  logic [111:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [215:0] m_tdata;

  logic [5:0] joint_sign_mask;
  logic [215:0] pending_frames [$];
  int errors = 0;
  int poses_sent;
  int frames_seen = 0;
  int idle_cycles = 0;
  bit hold_output;
  bit stalls_on;
  bit gaps_on;

  mdh_forward_kinematics_6dof uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint round_q(longint v, int s);
    longint w;
    w = v + (64'sd1 << (s - 1));
    if (w >= 0) return w >>> s;
    return -((-w + (64'sd1 << s) - 1) >>> s);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic joint_trig(input longint theta, output longint sn, output longint cs);
    logic [63:0] prod;
    logic [31:0] phase;
    logic [1:0] quad;
    longint r, s, c;
    logic [63:0] m, x, x2, t, sx, cx;
    bit neg;
    prod = theta * 64'sd10680707;
    phase = prod[39:8] + 32'h2000_0000;
    quad = phase[31:30];
    r = longint'({2'b0, phase[29:0]}) - 64'sh2000_0000;
    neg = r < 0;
    m = neg ? -r : r;
    x = (m * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = ONE_Q30 - x2 / 42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 6;
    sx = (x * t) >> 30;
    t = ONE_Q30 - x2 / 56;
    t = ONE_Q30 - ((x2 * t) >> 30) / 30;
    t = ONE_Q30 - ((x2 * t) >> 30) / 12;
    cx = ONE_Q30 - ((x2 * t) >> 30) / 2;
    s = (sx + 32) >> 6;
    c = (cx + 32) >> 6;
    if (neg) s = -s;
    case (quad)
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endtask

  task automatic predict_frame(input pose_t p, output logic [215:0] packed_frame);
    frame_t acc, lk, nx;
    longint q, st, ct, sum;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++) acc[i][j] = (i == j) ? ONE_Q24 : 0;
    if (p.chain_end < 6) begin
      for (int jt = 0; jt <= p.chain_end; jt++) begin
        q = p.angle[jt];
        if (joint_sign_mask[jt]) q = -q;
        joint_trig(q + ZERO_ANGLE[jt], st, ct);
        lk[0] = '{ct, -st, 0, LINK_A[jt]};
        if (TWISTED[jt]) begin
          lk[1] = '{0, 0, -ONE_Q24, -LINK_D[jt]};
          lk[2] = '{st, ct, 0, 0};
        end else begin
          lk[1] = '{st, ct, 0, 0};
          lk[2] = '{0, 0, ONE_Q24, LINK_D[jt]};
        end
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 4; j++) begin
            sum = 0;
            for (int k = 0; k < 3; k++) sum += acc[i][k] * lk[k][j];
            if (j == 3) sum += acc[i][3] * ONE_Q24;
            nx[i][j] = round_q(sum, 24);
          end
        acc = nx;
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++)
        packed_frame[(i*3+j)*18 +: 18] = 18'(clip(round_q(acc[i][j], 8), -65536, 65536));
      packed_frame[(9+i)*18 +: 18] = 18'(clip(round_q(acc[i][3], 8), -131072, 131071));
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch at frame %0d: %s got %0d expected %0d", frames_seen, what, got, want);
  endtask

  // check each output transaction against the oldest prediction
  always @(posedge clk) begin
    logic [215:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected frame", 0, 0);
      end else begin
        want = pending_frames.pop_front();
        for (int f = 0; f < 12; f++)
          if (m_tdata[f*18 +: 18] !== want[f*18 +: 18])
            report_mismatch($sformatf("field %0d", f), $signed(m_tdata[f*18 +: 18]),
                            $signed(want[f*18 +: 18]));
      end
      frames_seen++;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transactions for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall pattern, overridden by long holds
  always @(posedge clk) begin
    if (hold_output) m_tready <= 1'b0;
    else if (!stalls_on) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
  end

  task automatic send_pose(input pose_t p);
    logic [215:0] want;
    logic [111:0] word;
    word = '0;
    for (int j = 0; j < 6; j++) word[j*18 +: 18] = p.angle[j];
    word[108 +: 3] = p.chain_end;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
    predict_frame(p, want);
    pending_frames.push_back(want);
    poses_sent++;
  endtask

  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_mask(input logic [5:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    joint_sign_mask = v;
  endtask

  function automatic angle_t rand_angle();
    case ($urandom_range(0, 5))
      0: return -18'sd131072;
      1: return 18'sd131071;
      2: return angle_t'($urandom_range(0, 60) - 30);
      default: return angle_t'($urandom());
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    for (int j = 0; j < 6; j++) p.angle[j] = rand_angle();
    p.chain_end = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd5;
    return p;
  endfunction

  task automatic test_directed();
    pose_t p;
    angle_t picks [6] = '{0, -18'sd131072, 18'sd131071, 18'sd25736, -18'sd25736, 18'sd12868};
    for (int e = 0; e < 8; e++) begin
      for (int j = 0; j < 6; j++) p.angle[j] = picks[(j + e) % 6];
      p.chain_end = 3'(e);
      send_pose(p);
    end
    for (int k = 0; k < 6; k++) begin
      for (int j = 0; j < 6; j++) p.angle[j] = picks[k];
      p.chain_end = 3'd5;
      send_pose(p);
    end
    drain_pipeline();
  endtask

  task automatic test_masks();
    logic [5:0] masks [4] = '{6'd0, 6'd63, 6'b101010, 6'b010101};
    foreach (masks[i]) begin
      write_mask(masks[i]);
      repeat (30) send_pose(rand_pose());
      drain_pipeline();
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_output = 1;
        repeat (300) @(posedge clk);
        hold_output = 0;
      end
      repeat (80) send_pose(rand_pose());
    join
    drain_pipeline();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      write_mask(6'($urandom_range(0, 63)));
      stalls_on = phase != 1;
      gaps_on = phase != 1;
      repeat (120) send_pose(rand_pose());
      drain_pipeline();
    end
    write_mask(6'd63);
  endtask

  initial begin
    poses_sent = 0;
    hold_output = 0;
    stalls_on = 1;
    gaps_on = 1;
    joint_sign_mask = 6'd63;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_masks();
    test_backpressure();
    test_random();
    $display("covered %0d poses and %0d frames: directed extremes, all chain ends,",
             poses_sent, frames_seen);
    $display("sign masks 0, 63 and mixed, a long output hold, random gaps and stalls");
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
